// ===== rtl/mpool_pkg.sv =====
`timescale 1ns / 1ps
// Package for the max pooling window core: shared types, register codes and constants.
// Depends on nothing; used by every module of the block but mpool_ram.
package mpool_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int DIM_W        = 11;
    localparam int POOL_W       = 5;
    localparam int STRIDE_W     = 4;
    localparam int PAD_W        = 4;
    localparam int COORD_W      = 16;
    localparam int POS_W        = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 9;
    localparam int DIM_REG_W    = 9;
    localparam int POOL_REG_W   = 4;
    localparam int STRIDE_REG_W = 4;
    localparam int PAD_REG_W    = 4;
    localparam int STRIDE_MAX   = 8;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COORD_W-1:0]     coord_t;

    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    localparam logic [DIM_REG_W-1:0]    IN_WIDTH_RST  = DIM_REG_W'(13);
    localparam logic [DIM_REG_W-1:0]    IN_HEIGHT_RST = DIM_REG_W'(13);
    localparam logic [POOL_REG_W-1:0]   POOL_RST      = POOL_REG_W'(2);
    localparam logic [STRIDE_REG_W-1:0] STRIDE_RST    = STRIDE_REG_W'(2);
    localparam logic [PAD_REG_W-1:0]    PAD_RST       = PAD_REG_W'(0);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_WIDTH  = 3'd0,
        REG_IN_HEIGHT = 3'd1,
        REG_POOL_SIZE = 3'd2,
        REG_STRIDE    = 3'd3,
        REG_PADDING   = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } req_t;

    // Clamped configuration as seen by the window sequencer.
    typedef struct packed {
        logic [DIM_W-1:0]    in_width;
        logic [DIM_W-1:0]    in_height;
        logic [POOL_W-1:0]   pool_size;
        logic [STRIDE_W-1:0] stride;
        logic [PAD_W-1:0]    padding;
    } cfg_t;

endpackage

// ===== rtl/mpool_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Depends on nothing.
module mpool_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/mpool_cfg.sv =====
`timescale 1ns / 1ps
// Configuration register file of the max pooling core; presents clamped values.
// Depends on mpool_pkg.
module mpool_cfg #(
    parameter int MAX_PLANE_SIDE = 256,
    parameter int MAX_POOL       = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mpool_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [mpool_pkg::CFG_DATA_W-1:0]  cfg_data,
    output mpool_pkg::cfg_t                   cfg
);
    import mpool_pkg::*;

    logic [DIM_REG_W-1:0]    in_width_reg;
    logic [DIM_REG_W-1:0]    in_height_reg;
    logic [POOL_REG_W-1:0]   pool_size_reg;
    logic [STRIDE_REG_W-1:0] stride_reg;
    logic [PAD_REG_W-1:0]    padding_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_width_reg  <= IN_WIDTH_RST;
            in_height_reg <= IN_HEIGHT_RST;
            pool_size_reg <= POOL_RST;
            stride_reg    <= STRIDE_RST;
            padding_reg   <= PAD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_addr)
                REG_IN_WIDTH:  in_width_reg  <= cfg_data[DIM_REG_W-1:0];
                REG_IN_HEIGHT: in_height_reg <= cfg_data[DIM_REG_W-1:0];
                REG_POOL_SIZE: pool_size_reg <= cfg_data[POOL_REG_W-1:0];
                REG_STRIDE:    stride_reg    <= cfg_data[STRIDE_REG_W-1:0];
                REG_PADDING:   padding_reg   <= cfg_data[PAD_REG_W-1:0];
                default:       ;
            endcase
        end
    end

    // Saturate all but padding to the ranges the sequencer supports.
    always_comb
    begin
        if (in_width_reg == '0)
            cfg.in_width = DIM_W'(1);
        else if (DIM_W'(in_width_reg) > DIM_W'(MAX_PLANE_SIDE))
            cfg.in_width = DIM_W'(MAX_PLANE_SIDE);
        else
            cfg.in_width = DIM_W'(in_width_reg);

        if (in_height_reg == '0)
            cfg.in_height = DIM_W'(1);
        else if (DIM_W'(in_height_reg) > DIM_W'(MAX_PLANE_SIDE))
            cfg.in_height = DIM_W'(MAX_PLANE_SIDE);
        else
            cfg.in_height = DIM_W'(in_height_reg);

        if (pool_size_reg == '0)
            cfg.pool_size = POOL_W'(1);
        else if (POOL_W'(pool_size_reg) > POOL_W'(MAX_POOL))
            cfg.pool_size = POOL_W'(MAX_POOL);
        else
            cfg.pool_size = POOL_W'(pool_size_reg);

        if (stride_reg == '0)
            cfg.stride = STRIDE_W'(1);
        else if (stride_reg > STRIDE_W'(STRIDE_MAX))
            cfg.stride = STRIDE_W'(STRIDE_MAX);
        else
            cfg.stride = stride_reg;

        cfg.padding = padding_reg;
    end

endmodule

// ===== rtl/mpool_ctrl.sv =====
`timescale 1ns / 1ps
// Request sequencer of the max pooling core: writes loads into the plane store,
// walks the window of a query over the store read port and holds the result.
// Depends on mpool_pkg; drives one mpool_ram instance.
module mpool_ctrl #(
    parameter int MAX_PLANE_SIDE = 256,
    parameter int MAX_POOL       = 8
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  mpool_pkg::cfg_t                                    cfg,
    input  logic                                               req_valid,
    output logic                                               req_ready,
    input  mpool_pkg::req_t                                    req_type,
    input  logic [mpool_pkg::POS_W-1:0]                        in_col,
    input  logic [mpool_pkg::POS_W-1:0]                        in_row,
    input  mpool_pkg::sample_t                                 sample,
    input  logic [mpool_pkg::POS_W-1:0]                        out_col,
    input  logic [mpool_pkg::POS_W-1:0]                        out_row,
    output logic                                               res_valid,
    input  logic                                               res_ready,
    output mpool_pkg::sample_t                                 pooled_max,
    output logic                                               any_valid,
    output logic                                               bad_query,
    output logic                                               wr_en,
    output logic [$clog2(MAX_PLANE_SIDE*MAX_PLANE_SIDE)-1:0]   wr_addr,
    output mpool_pkg::sample_t                                 wr_data,
    output logic                                               rd_en,
    output logic [$clog2(MAX_PLANE_SIDE*MAX_PLANE_SIDE)-1:0]   rd_addr,
    input  mpool_pkg::sample_t                                 rd_data
);
    import mpool_pkg::*;

    localparam int ADDR_W = $clog2(MAX_PLANE_SIDE * MAX_PLANE_SIDE);
    localparam int SIDE_W = $clog2(MAX_PLANE_SIDE);
    localparam int CNT_W  = (MAX_POOL > 2) ? $clog2(MAX_POOL) : 1;
    localparam int PROD_W = POS_W + STRIDE_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic [POS_W-1:0]    ox_reg;
    logic [POS_W-1:0]    oy_reg;
    logic [PROD_W-1:0]   prod_x_reg;
    logic [PROD_W-1:0]   prod_y_reg;
    coord_t              x_base_reg;
    coord_t              y_base_reg;
    logic [CNT_W-1:0]    dx_reg;
    logic [CNT_W-1:0]    dy_reg;
    logic                bad_reg;
    sample_t             best_reg;
    logic                any_reg;
    logic                rd_pend_reg;
    logic                res_valid_reg;
    sample_t             pooled_reg;
    logic                any_out_reg;
    logic                bad_out_reg;

    logic                accept;
    coord_t              x0;
    coord_t              y0;
    logic                in_image;
    logic                last_dx;
    logic                last_dy;
    coord_t              n_x;
    coord_t              n_y;
    coord_t              half_pad;
    logic                bad_x;
    logic                bad_y;
    logic                take;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;

    assign wr_en   = accept && (req_type == REQ_LOAD)
                     && (32'(in_col) < MAX_PLANE_SIDE) && (32'(in_row) < MAX_PLANE_SIDE);
    assign wr_addr = ADDR_W'(ADDR_W'(in_row) * ADDR_W'(MAX_PLANE_SIDE) + ADDR_W'(in_col));
    assign wr_data = sample;

    always_comb
    begin
        x0       = x_base_reg + coord_t'(dx_reg);
        y0       = y_base_reg + coord_t'(dy_reg);
        in_image = (x0 >= 0) && (x0 < coord_t'(cfg.in_width))
                   && (y0 >= 0) && (y0 < coord_t'(cfg.in_height));
        last_dx  = (POOL_W'(dx_reg) == cfg.pool_size - POOL_W'(1));
        last_dy  = (POOL_W'(dy_reg) == cfg.pool_size - POOL_W'(1));
        rd_en    = (state_reg == ST_SCAN) && in_image;
        rd_addr  = ADDR_W'(ADDR_W'(y0[SIDE_W-1:0]) * ADDR_W'(MAX_PLANE_SIDE)
                   + ADDR_W'(x0[SIDE_W-1:0]));

        // Position lies beyond the output plane when pos * stride exceeds
        // in - pool + pad; a negative span leaves only position zero, and only
        // while the span is shorter than the stride.
        half_pad = coord_t'(cfg.padding >> 1);
        n_x      = coord_t'(cfg.in_width) - coord_t'(cfg.pool_size) + coord_t'(cfg.padding);
        n_y      = coord_t'(cfg.in_height) - coord_t'(cfg.pool_size) + coord_t'(cfg.padding);
        if (n_x >= 0)
            bad_x = coord_t'(prod_x_reg) > n_x;
        else
            bad_x = (ox_reg != '0) || (-n_x >= coord_t'(cfg.stride));
        if (n_y >= 0)
            bad_y = coord_t'(prod_y_reg) > n_y;
        else
            bad_y = (oy_reg != '0) || (-n_y >= coord_t'(cfg.stride));

        take = rd_pend_reg && (!any_reg || (rd_data > best_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ox_reg        <= '0;
            oy_reg        <= '0;
            prod_x_reg    <= '0;
            prod_y_reg    <= '0;
            x_base_reg    <= '0;
            y_base_reg    <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            bad_reg       <= 1'b0;
            best_reg      <= SAMPLE_MIN;
            any_reg       <= 1'b0;
            rd_pend_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            pooled_reg    <= SAMPLE_MIN;
            any_out_reg   <= 1'b0;
            bad_out_reg   <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && res_ready && (state_reg != ST_DONE))
            begin
                res_valid_reg <= 1'b0;
            end

            rd_pend_reg <= rd_en;
            if (take)
            begin
                best_reg <= rd_data;
            end
            if (rd_pend_reg)
            begin
                any_reg <= 1'b1;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (req_type == REQ_QUERY))
                    begin
                        ox_reg    <= out_col;
                        oy_reg    <= out_row;
                        best_reg  <= SAMPLE_MIN;
                        any_reg   <= 1'b0;
                        state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP:
                begin
                    prod_x_reg <= PROD_W'(ox_reg) * PROD_W'(cfg.stride);
                    prod_y_reg <= PROD_W'(oy_reg) * PROD_W'(cfg.stride);
                    state_reg  <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    x_base_reg <= coord_t'(prod_x_reg) - half_pad;
                    y_base_reg <= coord_t'(prod_y_reg) - half_pad;
                    bad_reg    <= bad_x || bad_y;
                    dx_reg     <= '0;
                    dy_reg     <= '0;
                    state_reg  <= (bad_x || bad_y) ? ST_DONE : ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (last_dx)
                    begin
                        dx_reg <= '0;
                        if (last_dy)
                            state_reg <= ST_DRAIN;
                        else
                            dy_reg <= dy_reg + CNT_W'(1);
                    end
                    else
                    begin
                        dx_reg <= dx_reg + CNT_W'(1);
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!res_valid_reg || res_ready)
                    begin
                        res_valid_reg <= 1'b1;
                        pooled_reg    <= best_reg;
                        any_out_reg   <= any_reg;
                        bad_out_reg   <= bad_reg;
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        res_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res_valid  = res_valid_reg;
    assign pooled_max = pooled_reg;
    assign any_valid  = any_out_reg;
    assign bad_query  = bad_out_reg;

endmodule

// ===== rtl/max_pool_2d_window_core.sv =====
`timescale 1ns / 1ps
// Top level of the 2-D max pooling core: configuration registers, request
// sequencer and plane store. Depends on mpool_pkg, mpool_cfg, mpool_ctrl, mpool_ram.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-----------------------------------
//   s_axis   | in        | tvalid / tready    | load sample or query position
//   m_axis   | out       | tvalid / tready    | window maximum and flags
//   cfg      | in        | valid / ready      | register index and write data
//
// A query scans one window position per cycle through the single store
// read port; a query beyond the output plane skips the scan. Reset clears
// control and configuration only; the plane store holds no reset value and
// is read at each in-image window position, loaded or not. A stalled
// result sits in the output register; a following load is still taken,
// and a following query finishes its scan before it waits.
module max_pool_2d_window_core #(
    parameter int MAX_PLANE_SIDE = 256,
    parameter int MAX_POOL       = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [47:0]                        s_axis_tdata,  // in_col, in_row, sample, out_col, out_row
    input  logic [0:0]                         s_axis_tuser,  // req_type
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [mpool_pkg::SAMPLE_BITS-1:0]  m_axis_tdata,  // pooled_max
    output logic [1:0]                         m_axis_tuser,  // any_valid, bad_query
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mpool_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [mpool_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mpool_pkg::*;

    localparam int DEPTH  = MAX_PLANE_SIDE * MAX_PLANE_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);

    cfg_t               cfg;
    req_t               req_type;
    sample_t            pooled_max;
    logic               any_valid;
    logic               bad_query;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    sample_t            wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    sample_t            rd_data;

    assign req_type = req_t'(s_axis_tuser[0]);

    mpool_cfg #(
        .MAX_PLANE_SIDE (MAX_PLANE_SIDE),
        .MAX_POOL       (MAX_POOL)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mpool_ctrl #(
        .MAX_PLANE_SIDE (MAX_PLANE_SIDE),
        .MAX_POOL       (MAX_POOL)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .req_valid  (s_axis_tvalid),
        .req_ready  (s_axis_tready),
        .req_type   (req_type),
        .in_col     (s_axis_tdata[7:0]),
        .in_row     (s_axis_tdata[15:8]),
        .sample     (sample_t'(s_axis_tdata[31:16])),
        .out_col    (s_axis_tdata[39:32]),
        .out_row    (s_axis_tdata[47:40]),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .pooled_max (pooled_max),
        .any_valid  (any_valid),
        .bad_query  (bad_query),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    mpool_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_plane_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_axis_tdata = pooled_max;
    assign m_axis_tuser = {bad_query, any_valid};

endmodule

// ===== rtl/mpool_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the max pooling core, bound to the top level.
// Depends on mpool_pkg and max_pool_2d_window_core.
module mpool_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [0:0]                         s_axis_tuser,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [mpool_pkg::SAMPLE_BITS-1:0]  m_axis_tdata,
    input  logic [1:0]                         m_axis_tuser
);
    import mpool_pkg::*;

    logic load_acc;
    logic query_acc;

    assign load_acc  = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == REQ_LOAD);
    assign query_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == REQ_QUERY);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_bad_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
        else $error("bad query reported a valid window");

    a_empty_min: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == SAMPLE_MIN)
        else $error("empty window without most negative value");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        query_acc |=> !s_axis_tready)
        else $error("request taken during window scan");

    a_load_single: assert property (@(posedge clk) disable iff (!rst_n)
        load_acc |=> s_axis_tready)
        else $error("load stalled the request channel");

endmodule

bind max_pool_2d_window_core mpool_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
